// ===== rtl/json_string_unescape_core_macros.svh =====
// ----------------------------------------------------------------------------
// json_string_unescape_core_macros.svh
// Assertion macros shared by the string unescape RTL.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_CORE_MACROS_SVH
`define JSON_STRING_UNESCAPE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define JSU_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("jsu assertion failed");

// Next-cycle implication, checked out of reset.
`define JSU_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("jsu assertion failed");

`else

`define JSU_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons)
`define JSU_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

// ===== rtl/jsu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and constants of the JSON string unescape block.
// ----------------------------------------------------------------------------
package jsu_pkg;

	// result kinds
	localparam logic [1:0] KIND_UNIT     = 2'd0;
	localparam logic [1:0] KIND_CLOSED   = 2'd1;
	localparam logic [1:0] KIND_NO_QUOTE = 2'd2;
	localparam logic [1:0] KIND_UNTERM   = 2'd3;

	// code units of interest
	localparam logic [15:0] U_QUOTE   = 16'h0022;
	localparam logic [15:0] U_BSLASH  = 16'h005C;
	localparam logic [15:0] U_SPACE   = 16'h0020;
	localparam logic [15:0] U_TAB     = 16'h0009;
	localparam logic [15:0] U_CR      = 16'h000D;
	localparam logic [15:0] U_LF      = 16'h000A;
	localparam logic [15:0] U_LOW_N   = 16'h006E;
	localparam logic [15:0] U_LOW_T   = 16'h0074;
	localparam logic [15:0] U_LOW_R   = 16'h0072;
	localparam logic [15:0] U_LOW_U   = 16'h0075;
	localparam logic [15:0] U_REPLACE = 16'hFFFD;
	localparam logic [15:0] HI_SURR_LO = 16'hD800;
	localparam logic [15:0] HI_SURR_HI = 16'hDBFF;
	localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

	localparam int unsigned MAX_RES = 3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] value;
	} res_t;

	// results caused by one input word
	typedef struct packed {
		logic [1:0]          cnt;
		res_t [MAX_RES-1:0]  r;
	} res_grp_t;

endpackage
`default_nettype wire

// ===== rtl/json_string_unescape_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_core
// Streaming JSON string decoder over UTF-16 code units.
// ----------------------------------------------------------------------------
// Input channel s_*: one UTF-16 code unit per word in s_tdata, s_tlast marks
// the last unit of a text buffer. Output channel m_*: decoded units and status
// words; m_tuser carries the kind (unit, string closed, no opening quote,
// unterminated), m_tlast flags the final result word caused by an input word.
// Leading whitespace is skipped, the opening quote is required, escapes and
// \uXXXX (with surrogate pairs) are decoded up to the closing quote.
//
// Pipeline: an accepted word waits in the input register until the result
// register is free; its results are then decoded into the result register,
// which drives m_*.
// Throughput: one input word per cycle while m_tready is high and each word
// gives at most one result. A word with several results holds the result
// register while the single port sends one per cycle. Words with no result
// (whitespace, digits of an escape, text after the string) pass without
// using the output port.
// Reset: arst_n clears the decoder to idle (awaiting the opening quote) and
// empties both registers. A stalled m_tready holds the current result; the
// input register still takes one more word, then s_tready drops.
// ----------------------------------------------------------------------------
module json_string_unescape_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] code_unit
	input  wire logic        s_tlast,   // end_of_buffer
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [15:0] unit_value
	output logic [1:0]       m_tuser,   // [1:0] kind
	output logic             m_tlast    // last_of_item
);
	import jsu_pkg::*;

	// input register
	logic        valid_s1;
	logic [15:0] unit_s1;
	logic        eob_s1;

	logic        accept;
	logic        move;
	logic        free;
	res_grp_t    grp;

	// a word moves on once the result register has room for its results
	assign move     = valid_s1 && free;
	assign s_tready = !valid_s1 || free;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			unit_s1 <= s_tdata;
			eob_s1  <= s_tlast;
		end
	end

	// escape state machine, state advances with each word that moves on
	jsu_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (move),
		.unit   (unit_s1),
		.eob    (eob_s1),
		.grp    (grp)
	);

	// result register and output sequencing
	jsu_serializer u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (move),
		.grp      (grp),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// ===== rtl/jsu_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_decode
// Escape state machine: state registers plus the per-word decode logic.
// ----------------------------------------------------------------------------
module jsu_decode (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic [15:0]        unit,
	input  wire logic               eob,
	output jsu_pkg::res_grp_t       grp
);
	import jsu_pkg::*;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_STR    = 3'd1;
	localparam logic [2:0] PH_ESC    = 3'd2;
	localparam logic [2:0] PH_HEX1   = 3'd3;
	localparam logic [2:0] PH_HELD   = 3'd4;
	localparam logic [2:0] PH_HELDBS = 3'd5;
	localparam logic [2:0] PH_HEX2   = 3'd6;
	localparam logic [2:0] PH_SKIP   = 3'd7;

	logic [2:0]  phase_q;
	logic [15:0] acc_q;
	logic [1:0]  dc_q;
	logic [15:0] held_q;

	logic [2:0]  phase_d;
	logic [15:0] acc_d;
	logic [1:0]  dc_d;
	logic [15:0] held_d;

	function automatic res_grp_t push(input res_grp_t g, input logic [1:0] k,
			input logic [15:0] v);
		res_grp_t o;
		o = g;
		o.r[o.cnt].kind  = k;
		o.r[o.cnt].value = v;
		o.cnt = o.cnt + 2'd1;
		return o;
	endfunction

	// hi is a held high surrogate, so only its low 10 bits matter;
	// cp = 0x10000 + (hi-0xD800)<<10 + lo-0xDC00 never wraps here
	function automatic res_grp_t push_pair(input res_grp_t g, input logic [15:0] hi,
			input logic [15:0] lo);
		res_grp_t o;
		logic [20:0] cp;
		logic [20:0] c;
		cp = {1'b0, hi[9:0], 10'd0} + {5'd0, lo} + 21'h002400;
		if (cp >= 21'h010000) begin
			c = cp - 21'h010000;
			o = push(g, KIND_UNIT, HI_SURR_LO + {5'd0, c[20:10]});
			o = push(o, KIND_UNIT, LO_SURR_BASE + {6'd0, c[9:0]});
		end else begin
			o = push(g, KIND_UNIT, cp[15:0]);
		end
		return o;
	endfunction

	always_comb begin
		res_grp_t    g;
		logic        do_str;
		logic        do_esc;
		logic        dv;
		logic [3:0]  d;
		logic [15:0] uoff;

		g       = '0;
		do_str  = 1'b0;
		do_esc  = 1'b0;
		phase_d = phase_q;
		acc_d   = acc_q;
		dc_d    = dc_q;
		held_d  = held_q;

		// hex digit
		dv = 1'b1;
		d  = 4'd0;
		if (unit >= 16'h0030 && unit <= 16'h0039) begin
			uoff = unit - 16'h0030;
			d    = uoff[3:0];
		end else if (unit >= 16'h0061 && unit <= 16'h0066) begin
			uoff = unit - 16'h0057;
			d    = uoff[3:0];
		end else if (unit >= 16'h0041 && unit <= 16'h0046) begin
			uoff = unit - 16'h0037;
			d    = uoff[3:0];
		end else begin
			uoff = '0;
			dv   = 1'b0;
		end

		case (phase_q)
			PH_STR: begin
				do_str = 1'b1;
			end
			PH_ESC: begin
				do_esc = 1'b1;
			end
			PH_HEX1, PH_HEX2: begin
				if (!dv) begin
					acc_d = U_REPLACE;
				end else begin
					acc_d = {acc_q[11:0], d};
				end
				if (!dv || dc_q == 2'd3) begin
					if (phase_q == PH_HEX1) begin
						if (acc_d >= HI_SURR_LO && acc_d <= HI_SURR_HI) begin
							held_d  = acc_d;
							phase_d = PH_HELD;
						end else begin
							g       = push(g, KIND_UNIT, acc_d);
							phase_d = PH_STR;
						end
					end else begin
						g       = push_pair(g, held_q, acc_d);
						phase_d = PH_STR;
					end
					acc_d = '0;
					dc_d  = '0;
				end else begin
					dc_d = dc_q + 2'd1;
				end
			end
			PH_HELD: begin
				if (unit == U_BSLASH) begin
					phase_d = PH_HELDBS;
				end else begin
					g      = push(g, KIND_UNIT, held_q);
					do_str = 1'b1;
				end
			end
			PH_HELDBS: begin
				if (unit == U_LOW_U) begin
					acc_d   = '0;
					dc_d    = '0;
					phase_d = PH_HEX2;
				end else begin
					g      = push(g, KIND_UNIT, held_q);
					do_esc = 1'b1;
				end
			end
			PH_SKIP: begin
				phase_d = PH_SKIP;
			end
			default: begin
				if (unit == U_QUOTE) begin
					phase_d = PH_STR;
				end else if (unit == U_SPACE || unit == U_TAB || unit == U_CR ||
						unit == U_LF) begin
					phase_d = PH_IDLE;
				end else begin
					g       = push(g, KIND_NO_QUOTE, 16'd0);
					phase_d = PH_SKIP;
				end
			end
		endcase

		if (do_str) begin
			if (unit == U_QUOTE) begin
				g       = push(g, KIND_CLOSED, 16'd0);
				phase_d = PH_SKIP;
			end else if (unit == U_BSLASH) begin
				phase_d = PH_ESC;
			end else begin
				g       = push(g, KIND_UNIT, unit);
				phase_d = PH_STR;
			end
		end

		if (do_esc) begin
			phase_d = PH_STR;
			case (unit)
				U_LOW_N: g = push(g, KIND_UNIT, U_LF);
				U_LOW_T: g = push(g, KIND_UNIT, U_TAB);
				U_LOW_R: g = push(g, KIND_UNIT, U_CR);
				U_LOW_U: begin
					acc_d   = '0;
					dc_d    = '0;
					phase_d = PH_HEX1;
				end
				default: g = push(g, KIND_UNIT, unit);
			endcase
		end

		// end of buffer flushes whatever is pending
		if (eob) begin
			case (phase_d)
				PH_STR: g = push(g, KIND_UNTERM, 16'd0);
				PH_ESC: begin
					g = push(g, KIND_UNIT, U_BSLASH);
					g = push(g, KIND_UNTERM, 16'd0);
				end
				PH_HEX1: begin
					g = push(g, KIND_UNIT, acc_d);
					g = push(g, KIND_UNTERM, 16'd0);
				end
				PH_HELD: begin
					g = push(g, KIND_UNIT, held_d);
					g = push(g, KIND_UNTERM, 16'd0);
				end
				PH_HELDBS: begin
					g = push(g, KIND_UNIT, held_d);
					g = push(g, KIND_UNIT, U_BSLASH);
					g = push(g, KIND_UNTERM, 16'd0);
				end
				PH_HEX2: begin
					g = push_pair(g, held_d, acc_d);
					g = push(g, KIND_UNTERM, 16'd0);
				end
				PH_SKIP: g = g;
				default: g = push(g, KIND_NO_QUOTE, 16'd0);
			endcase
			phase_d = PH_IDLE;
			acc_d   = '0;
			dc_d    = '0;
		end

		grp = g;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			dc_q    <= '0;
			held_q  <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			dc_q    <= dc_d;
			held_q  <= held_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/jsu_serializer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_serializer
// Result register: holds the results of one word, sends one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module jsu_serializer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire jsu_pkg::res_grp_t  grp,
	output logic                    free,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [15:0]             m_tdata,   // [15:0] unit_value
	output logic [1:0]              m_tuser,   // [1:0] kind
	output logic                    m_tlast    // last_of_item
);
	import jsu_pkg::*;

	res_t [MAX_RES-1:0] res_q;
	logic [1:0]         cnt_q;
	logic [1:0]         idx_q;
	logic               take;
	logic               last;

	assign m_tvalid = (cnt_q != 2'd0);
	assign take     = m_tvalid && m_tready;
	assign last     = (idx_q == cnt_q - 2'd1);
	assign free     = !m_tvalid || (take && last);

	assign m_tdata = res_q[idx_q].value;
	assign m_tuser = res_q[idx_q].kind;
	assign m_tlast = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= grp.cnt;
			idx_q <= '0;
		end else if (take) begin
			if (last) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= grp.r;
		end
	end

`include "json_string_unescape_core_macros.svh"

	`JSU_ASSERT_NOW(a_idx_in_range, clk, arst_n, m_tvalid, idx_q < cnt_q)
	`JSU_ASSERT_NOW(a_load_only_free, clk, arst_n, load, free)
	`JSU_ASSERT_NEXT(a_step_word, clk, arst_n, take && !last && !load,
		idx_q == $past(idx_q) + 2'd1 && cnt_q == $past(cnt_q))

endmodule
`default_nettype wire

// ===== dv/json_string_unescape_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_core_tb
// Self-checking bench for the streaming JSON string decoder. A short table of
// hand-picked code units comes first, then random text buffers: whitespace,
// an opening quote, plain text, escapes, \u sequences, surrogate pairs, bad
// hex digits and every kind of truncated ending, plus some pure noise. An
// in-bench decoder predicts each result word. Both handshakes idle at random,
// and the result side is held off long enough to back the input up.
// ----------------------------------------------------------------------------
module json_string_unescape_core_tb;
	import jsu_pkg::*;

	localparam int          DIR_N        = 31;
	localparam int          RAND_ITEMS   = 100;
	localparam int          LONG_HOLD    = 80;
	localparam logic [31:0] SUPP_BASE    = 32'h0001_0000;
	localparam logic [31:0] TEN_BIT_MASK = 32'h0000_03FF;
	// hex digit ranges
	localparam logic [15:0] DIG_0 = 16'h0030;
	localparam logic [15:0] DIG_9 = 16'h0039;
	localparam logic [15:0] UC_A  = 16'h0041;
	localparam logic [15:0] UC_F  = 16'h0046;
	localparam logic [15:0] LC_A  = 16'h0061;
	localparam logic [15:0] LC_F  = 16'h0066;
	localparam logic [15:0] U_SLASH = 16'h002F;

	typedef enum logic [3:0] {
		DS_WAIT_QUOTE, DS_TEXT, DS_ESCAPE, DS_HEX,
		DS_HIGH_HELD, DS_HIGH_BSLASH, DS_LOW_HEX, DS_DISCARD
	} dec_state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] value;
		logic        last;
	} unit_word_t;

	typedef struct {
		logic [15:0] cu;
		logic        eob;
		bit          pinned;
		int          pin_cnt;
		logic [1:0]  pin_kind;
		logic [15:0] pin_val;
	} dir_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	json_string_unescape_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [15:0] code_unit
		.s_tlast  (s_tlast),   // end_of_buffer
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [15:0] unit_value
		.m_tuser  (m_tuser),   // [1:0] kind
		.m_tlast  (m_tlast)    // last_of_item
	);

	always #5 clk = ~clk;

	// decoder state mirrored by the bench
	dec_state_t  dec_ph  = DS_WAIT_QUOTE;
	logic [15:0] hex_acc = '0;
	logic [15:0] held_hi = '0;
	int          dig_cnt = 0;

	unit_word_t  step_words[$];
	unit_word_t  expected_words[$];
	logic [15:0] buf_units[$];

	int n_fail      = 0;
	int total_items = 0;
	int live_items  = 0;
	int n_buffers   = 0;
	int n_checked   = 0;
	int kind_seen [4] = '{0, 0, 0, 0};
	bit calm         = 1'b0;
	bit hold_off_req = 1'b0;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic void push_word(input logic [1:0] kind, input logic [15:0] val);
		unit_word_t w;
		w.kind  = kind;
		w.value = val;
		w.last  = 1'b0;
		if (step_words.size() < MAX_RES)
			step_words = {step_words, w};
	endfunction

	// one code point out, split into a surrogate pair above the BMP
	function automatic void push_code_point(input logic [31:0] cp);
		logic [31:0] t, hi_w, lo_w;
		if (cp >= SUPP_BASE) begin
			t    = cp - SUPP_BASE;
			hi_w = {16'h0, HI_SURR_LO} + (t >> 10);
			lo_w = {16'h0, LO_SURR_BASE} + (t & TEN_BIT_MASK);
			push_word(KIND_UNIT, hi_w[15:0]);
			push_word(KIND_UNIT, lo_w[15:0]);
		end else begin
			push_word(KIND_UNIT, cp[15:0]);
		end
	endfunction

	// low half is not range checked; 32-bit wraparound is intended
	function automatic void push_pair(input logic [15:0] hi, input logic [15:0] lo);
		logic [31:0] cp;
		cp = SUPP_BASE + (({16'h0, hi} - {16'h0, HI_SURR_LO}) << 10)
			+ ({16'h0, lo} - {16'h0, LO_SURR_BASE});
		push_code_point(cp);
	endfunction

	function automatic int hex_digit(input logic [15:0] c);
		if (c >= DIG_0 && c <= DIG_9) return int'(c - DIG_0);
		if (c >= LC_A && c <= LC_F) return int'(c - LC_A) + 10;
		if (c >= UC_A && c <= UC_F) return int'(c - UC_A) + 10;
		return -1;
	endfunction

	function automatic void text_unit(input logic [15:0] c);
		if (c == U_QUOTE) begin
			push_word(KIND_CLOSED, 16'h0);
			dec_ph = DS_DISCARD;
		end else if (c == U_BSLASH) begin
			dec_ph = DS_ESCAPE;
		end else begin
			push_word(KIND_UNIT, c);
		end
	endfunction

	function automatic void escape_unit(input logic [15:0] c);
		dec_ph = DS_TEXT;
		case (c)
			U_LOW_N: push_word(KIND_UNIT, U_LF);
			U_LOW_T: push_word(KIND_UNIT, U_TAB);
			U_LOW_R: push_word(KIND_UNIT, U_CR);
			U_LOW_U: begin
				hex_acc = '0;
				dig_cnt = 0;
				dec_ph  = DS_HEX;
			end
			default: push_word(KIND_UNIT, c);
		endcase
	endfunction

	// result of the first \u: hold a high surrogate, emit anything else
	function automatic void first_done(input logic [15:0] v);
		if (v >= HI_SURR_LO && v <= HI_SURR_HI) begin
			held_hi = v;
			dec_ph  = DS_HIGH_HELD;
		end else begin
			push_word(KIND_UNIT, v);
			dec_ph = DS_TEXT;
		end
	endfunction

	// advance the mirrored decoder by one code unit; fills step_words
	function automatic void predict_unit(input logic [15:0] c, input logic eob);
		int d;
		step_words.delete();
		case (dec_ph)
			DS_TEXT:   text_unit(c);
			DS_ESCAPE: escape_unit(c);
			DS_HEX, DS_LOW_HEX: begin
				d = hex_digit(c);
				if (d < 0) begin
					hex_acc = U_REPLACE;
				end else begin
					hex_acc = {hex_acc[11:0], d[3:0]};
					dig_cnt = dig_cnt + 1;
				end
				if (d < 0 || dig_cnt >= 4) begin
					if (dec_ph == DS_HEX) begin
						first_done(hex_acc);
					end else begin
						push_pair(held_hi, hex_acc);
						dec_ph = DS_TEXT;
					end
					hex_acc = '0;
					dig_cnt = 0;
				end
			end
			DS_HIGH_HELD: begin
				if (c == U_BSLASH) begin
					dec_ph = DS_HIGH_BSLASH;
				end else begin
					push_word(KIND_UNIT, held_hi);
					dec_ph = DS_TEXT;
					text_unit(c);
				end
			end
			DS_HIGH_BSLASH: begin
				if (c == U_LOW_U) begin
					hex_acc = '0;
					dig_cnt = 0;
					dec_ph  = DS_LOW_HEX;
				end else begin
					push_word(KIND_UNIT, held_hi);
					escape_unit(c);
				end
			end
			DS_DISCARD: ;
			default: begin
				if (c == U_QUOTE)
					dec_ph = DS_TEXT;
				else if (!(c == U_SPACE || c == U_TAB || c == U_CR || c == U_LF)) begin
					push_word(KIND_NO_QUOTE, 16'h0);
					dec_ph = DS_DISCARD;
				end else
					dec_ph = DS_WAIT_QUOTE;
			end
		endcase

		// end of buffer flushes whatever is pending
		if (eob) begin
			case (dec_ph)
				DS_TEXT: push_word(KIND_UNTERM, 16'h0);
				DS_ESCAPE: begin
					push_word(KIND_UNIT, U_BSLASH);
					push_word(KIND_UNTERM, 16'h0);
				end
				DS_HEX: begin
					push_word(KIND_UNIT, hex_acc);
					push_word(KIND_UNTERM, 16'h0);
				end
				DS_HIGH_HELD: begin
					push_word(KIND_UNIT, held_hi);
					push_word(KIND_UNTERM, 16'h0);
				end
				DS_HIGH_BSLASH: begin
					push_word(KIND_UNIT, held_hi);
					push_word(KIND_UNIT, U_BSLASH);
					push_word(KIND_UNTERM, 16'h0);
				end
				DS_LOW_HEX: begin
					push_pair(held_hi, hex_acc);
					push_word(KIND_UNTERM, 16'h0);
				end
				DS_DISCARD: ;
				default: push_word(KIND_NO_QUOTE, 16'h0);
			endcase
			dec_ph  = DS_WAIT_QUOTE;
			hex_acc = '0;
			dig_cnt = 0;
		end

		if (step_words.size() > 0)
			step_words[step_words.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// random text buffers
	// ------------------------------------------------------------------
	function automatic void add_unit(input logic [15:0] c);
		buf_units = {buf_units, c};
	endfunction

	function automatic logic [15:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) return DIG_0 + 16'(nib);
		if ($urandom_range(0, 1) == 0) return UC_A + 16'(nib - 4'd10);
		return LC_A + 16'(nib - 4'd10);
	endfunction

	function automatic logic [15:0] bad_hex_char();
		logic [15:0] c;
		do begin
			case ($urandom_range(0, 4))
				0: c = 16'h0067;   // g
				1: c = 16'h0047;   // G
				2: c = 16'h003A;   // just past 9
				3: c = 16'h0040;   // just before A
				default: c = 16'($urandom);
			endcase
		end while (hex_digit(c) >= 0);
		return c;
	endfunction

	function automatic logic [15:0] ws_unit();
		case ($urandom_range(0, 3))
			0: return U_SPACE;
			1: return U_TAB;
			2: return U_CR;
			default: return U_LF;
		endcase
	endfunction

	function automatic logic [15:0] text_char();
		logic [15:0] c;
		if ($urandom_range(0, 1) == 0) return 16'($urandom);
		c = 16'($urandom_range(32, 126));
		if (c == U_QUOTE || c == U_BSLASH) c = UC_A;
		return c;
	endfunction

	function automatic logic [15:0] esc_char();
		case ($urandom_range(0, 6))
			0: return U_LOW_N;
			1: return U_LOW_T;
			2: return U_LOW_R;
			3: return U_QUOTE;
			4: return U_BSLASH;
			5: return U_SLASH;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] noise_unit();
		case ($urandom_range(0, 7))
			0: return U_QUOTE;
			1: return U_BSLASH;
			2: return ws_unit();
			3: return U_LOW_U;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void add_digits(input logic [15:0] v, input int n);
		for (int i = 0; i < n; i++)
			add_unit(hex_char(v[15 - 4*i -: 4]));
	endfunction

	function automatic void add_u_esc(input logic [15:0] v);
		add_unit(U_BSLASH);
		add_unit(U_LOW_U);
		add_digits(v, 4);
	endfunction

	function automatic logic [15:0] high_surr();
		return 16'($urandom_range(HI_SURR_LO, HI_SURR_HI));
	endfunction

	function automatic void add_segment();
		logic [15:0] c;
		case ($urandom_range(0, 7))
			0: add_unit(text_char());
			1: begin
				add_unit(U_BSLASH);
				add_unit(esc_char());
			end
			2: add_u_esc(16'($urandom));
			3: begin
				// proper pair most of the time, any low half otherwise
				add_u_esc(high_surr());
				if ($urandom_range(0, 3) != 0)
					add_u_esc(16'($urandom_range(LO_SURR_BASE, 16'hDFFF)));
				else
					add_u_esc(16'($urandom));
			end
			4: begin
				add_u_esc(high_surr());
				add_unit(($urandom_range(0, 4) == 0) ? U_QUOTE : text_char());
			end
			5: begin
				// held high surrogate released by another escape
				add_u_esc(high_surr());
				c = esc_char();
				if (c == U_LOW_U) c = U_LOW_N;
				add_unit(U_BSLASH);
				add_unit(c);
			end
			6: begin
				add_unit(U_BSLASH);
				add_unit(U_LOW_U);
				add_digits(16'($urandom), $urandom_range(0, 3));
				add_unit(bad_hex_char());
			end
			default: begin
				// bad digit in the low half
				add_u_esc(high_surr());
				add_unit(U_BSLASH);
				add_unit(U_LOW_U);
				add_digits(16'($urandom), $urandom_range(0, 3));
				add_unit(bad_hex_char());
			end
		endcase
	endfunction

	function automatic void gen_buffer();
		int sel;
		buf_units.delete();
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 5)) add_unit(noise_unit());
			return;
		end
		repeat ($urandom_range(0, 3)) add_unit(ws_unit());
		add_unit(U_QUOTE);
		repeat ($urandom_range(1, 6)) add_segment();
		sel = $urandom_range(0, 11);
		if (sel <= 5) begin
			// closed string, maybe with text after it that gets dropped
			add_unit(U_QUOTE);
			repeat ($urandom_range(0, 2)) add_unit(noise_unit());
		end else if (sel == 7) begin
			add_unit(U_BSLASH);
		end else if (sel == 8) begin
			add_unit(U_BSLASH);
			add_unit(U_LOW_U);
			add_digits(16'($urandom), $urandom_range(0, 3));
		end else if (sel == 9) begin
			add_u_esc(high_surr());
		end else if (sel == 10) begin
			add_u_esc(high_surr());
			add_unit(U_BSLASH);
		end else if (sel == 11) begin
			add_u_esc(high_surr());
			add_unit(U_BSLASH);
			add_unit(U_LOW_U);
			add_digits(16'($urandom), $urandom_range(0, 3));
		end
		// sel 6: buffer simply ends inside the string
	endfunction

	// ------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------
	task automatic send_word(input logic [15:0] c, input logic eob, input bit pinned,
		input int pin_cnt, input logic [1:0] pin_kind, input logic [15:0] pin_val);
		unit_word_t w;
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eob;
		do @(posedge clk); while (s_tready !== 1'b1);

		total_items++;
		if (dec_ph != DS_DISCARD) live_items++;
		predict_unit(c, eob);
		if (pinned) begin
			step_words.delete();
			if (pin_cnt > 0) begin
				w.kind  = pin_kind;
				w.value = pin_val;
				w.last  = 1'b1;
				step_words = {step_words, w};
			end
		end
		foreach (step_words[i]) expected_words = {expected_words, step_words[i]};
	endtask

	// stop offering words until every predicted result has come out
	task automatic wait_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_words.size() != 0);
	endtask

	// directed words; pinned rows carry their one obvious result (or none)
	dir_row_t dir_tab [DIR_N] = '{
		'{16'h0041,    1'b0, 1'b1, 1, KIND_NO_QUOTE, 16'h0000}, // text before any quote
		'{16'hFFFF,    1'b1, 1'b1, 0, KIND_UNIT,     16'h0000}, // ignored, buffer ends
		'{U_SPACE,     1'b1, 1'b1, 1, KIND_NO_QUOTE, 16'h0000}, // only whitespace
		'{U_TAB,       1'b0, 1'b1, 0, KIND_UNIT,     16'h0000},
		'{U_QUOTE,     1'b0, 1'b1, 0, KIND_UNIT,     16'h0000},
		'{16'h0000,    1'b0, 1'b1, 1, KIND_UNIT,     16'h0000}, // lowest unit
		'{16'hFFFF,    1'b0, 1'b1, 1, KIND_UNIT,     16'hFFFF}, // highest unit
		'{U_BSLASH,    1'b0, 1'b0, 0, KIND_UNIT,     16'h0000},
		'{U_LOW_N,     1'b0, 1'b1, 1, KIND_UNIT,     U_LF},
		'{U_BSLASH,    1'b0, 1'b0, 0, KIND_UNIT,     16'h0000},
		'{16'h0071,    1'b0, 1'b0, 0, KIND_UNIT,     16'h0000}, // unknown escape passes
		'{U_BSLASH,    1'b0, 1'b0, 0, KIND_UNIT,     16'h0000},
		'{U_LOW_U,     1'b0, 1'b0, 0, KIND_UNIT,     16'h0000},
		'{16'h0044,    1'b0, 1'b0, 0, KIND_UNIT,     16'h0000}, // D
		'{16'h0062,    1'b0, 1'b0, 0, KIND_UNIT,     16'h0000}, // b
		'{16'h0046,    1'b0, 1'b0, 0, KIND_UNIT,     16'h0000}, // F
		'{16'h0066,    1'b0, 1'b0, 0, KIND_UNIT,     16'h0000}, // f: high half held
		'{U_BSLASH,    1'b0, 1'b0, 0, KIND_UNIT,     16'h0000},
		'{U_LOW_U,     1'b0, 1'b0, 0, KIND_UNIT,     16'h0000},
		'{16'h0044,    1'b0, 1'b0, 0, KIND_UNIT,     16'h0000}, // D
		'{16'h0043,    1'b0, 1'b0, 0, KIND_UNIT,     16'h0000}, // C
		'{16'h0030,    1'b0, 1'b0, 0, KIND_UNIT,     16'h0000}, // 0
		'{16'h0030,    1'b0, 1'b0, 0, KIND_UNIT,     16'h0000}, // 0: pair out
		'{U_BSLASH,    1'b0, 1'b0, 0, KIND_UNIT,     16'h0000},
		'{U_LOW_U,     1'b0, 1'b0, 0, KIND_UNIT,     16'h0000},
		'{16'h0067,    1'b0, 1'b1, 1, KIND_UNIT,     U_REPLACE}, // bad hex digit
		'{U_QUOTE,     1'b0, 1'b1, 1, KIND_CLOSED,   16'h0000},
		'{16'h0078,    1'b1, 1'b1, 0, KIND_UNIT,     16'h0000}, // after close: dropped
		'{U_CR,        1'b0, 1'b1, 0, KIND_UNIT,     16'h0000},
		'{U_QUOTE,     1'b0, 1'b1, 0, KIND_UNIT,     16'h0000},
		'{U_BSLASH,    1'b1, 1'b0, 0, KIND_UNIT,     16'h0000}  // ends after backslash
	};

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_word(dir_tab[i].cu, dir_tab[i].eob, dir_tab[i].pinned,
				dir_tab[i].pin_cnt, dir_tab[i].pin_kind, dir_tab[i].pin_val);
		wait_results();

		while (total_items < DIR_N + RAND_ITEMS) begin
			// long result-side stall early on, sender keeps going
			if (n_buffers == 3) hold_off_req = 1'b1;
			if (n_buffers == 6) wait_results();
			if (total_items >= DIR_N + RAND_ITEMS - 25) calm = 1'b1;
			gen_buffer();
			foreach (buf_units[i])
				send_word(buf_units[i], i == buf_units.size() - 1, 1'b0, 0, KIND_UNIT, 16'h0);
			n_buffers++;
		end

		wait_results();
		repeat (20) @(posedge clk);
		$display("Sent %0d code units (%0d decoded, %0d random buffers), checked %0d words",
			total_items, live_items, n_buffers, n_checked);
		$display("Words by kind: unit %0d, closed %0d, no quote %0d, unterminated %0d",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
		if (n_fail == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// ------------------------------------------------------------------
	// receiver: random stall bursts, one long hold on request
	// ------------------------------------------------------------------
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_off_req = 1'b0;
				m_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_words
		unit_word_t w;
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			n_checked++;
			kind_seen[m_tuser]++;
			if (expected_words.size() == 0) begin
				$error("result word with none expected: kind %0d value %h last %b",
					m_tuser, m_tdata, m_tlast);
				n_fail++;
			end else begin
				w = expected_words.pop_front();
				if (m_tuser !== w.kind) begin
					$error("kind: expected %0d, got %0d", w.kind, m_tuser);
					n_fail++;
				end
				if (m_tdata !== w.value) begin
					$error("unit_value: expected %h, got %h", w.value, m_tdata);
					n_fail++;
				end
				if (m_tlast !== w.last) begin
					$error("last_of_item: expected %b, got %b", w.last, m_tlast);
					n_fail++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
